[rtl/core/qrs_pkg.sv]
// Package for the quadratic root solver: sizes, codes and shared types.
`default_nettype none

package qrs_pkg;

    // Field sizes of the coefficients and of the fixed-point roots.
    localparam int COEF_BITS = 16;
    localparam int FRAC_BITS = 14;
    localparam int ROOT_W    = 32;
    localparam int CNT_W     = 2;

    // Derived datapath widths.
    localparam int PROD_W = 2 * COEF_BITS;
    localparam int DISC_W = 2 * COEF_BITS + 2;
    localparam int RAD_W  = 2 * COEF_BITS + 1 + 2 * FRAC_BITS;
    localparam int SQ_W   = (RAD_W + 1) / 2;
    localparam int RADP_W = 2 * SQ_W;
    localparam int REM_W  = SQ_W + 2;
    localparam int UN_W   = SQ_W + 1;
    localparam int NS_W   = UN_W + 1;
    localparam int DEN_W  = COEF_BITS + 1;
    localparam int DENS_W = COEF_BITS + 2;
    localparam int QN_W   = UN_W + 1;
    localparam int SAT_W  = (QN_W > ROOT_W) ? QN_W : ROOT_W + 1;
    localparam int LANES  = 2;

    // Saturation bounds of a root magnitude.
    localparam logic [SAT_W-1:0] SAT_NEG = SAT_W'(1) << (ROOT_W - 1);
    localparam logic [SAT_W-1:0] SAT_POS = SAT_NEG - SAT_W'(1);

    // Root count codes.
    typedef enum logic [CNT_W-1:0] {
        CNT_NONE = 2'd0,
        CNT_ONE  = 2'd1,
        CNT_TWO  = 2'd2,
        CNT_ALL  = 2'd3
    } t_count;

    typedef logic signed [COEF_BITS-1:0] t_coef;
    typedef logic signed [DISC_W-1:0]    t_disc;
    typedef logic signed [NS_W-1:0]      t_num;
    typedef logic signed [DENS_W-1:0]    t_den;

    // Item state carried alongside the square root pipeline.
    typedef struct packed {
        t_coef  coef_a;
        t_coef  coef_b;
        t_coef  coef_c;
        t_disc  disc;
        t_count count;
    } t_pre;

    // Item state carried alongside the divider pipeline.
    typedef struct packed {
        t_disc  disc;
        t_count count;
    } t_side;

endpackage

`default_nettype wire

[rtl/core/qrs_if.sv]
// Valid/ready channel interfaces for coefficient items and result items.
`default_nettype none

interface qrs_in_if;
    logic          valid;
    logic          ready;
    qrs_pkg::t_coef coef_a;
    qrs_pkg::t_coef coef_b;
    qrs_pkg::t_coef coef_c;

    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if;
    logic                                valid;
    logic                                ready;
    logic [qrs_pkg::CNT_W-1:0]           root_count;
    logic signed [qrs_pkg::ROOT_W-1:0]   first_root;
    logic signed [qrs_pkg::ROOT_W-1:0]   second_root;
    logic signed [qrs_pkg::DISC_W-1:0]   discriminant;

    modport source (output valid, root_count, first_root, second_root, discriminant,
                    input ready);
    modport sink   (input valid, root_count, first_root, second_root, discriminant,
                    output ready);
endinterface

`default_nettype wire

[rtl/core/quadratic_root_solver.sv]
// Top level of the quadratic root solver: pipeline assembly and result register.
//
//  Channel  | Direction | Carries
//  ---------+-----------+--------------------------------------------------------
//  i_in     | in        | coef_a, coef_b, coef_c (signed 16-bit integers)
//  o_out    | out       | root_count, first_root, second_root (Q18.14), discriminant
//
//  One item enters per cycle while no result is held at the output; the stages in order are:
//  two front stages, 31 square root stages, one numerator stage, one divider
//  prepare stage, 33 quotient stages and the result register.
//  The whole pipeline advances together; it halts while a result waits at the output,
//  and i_in.ready is low exactly then. Reset clears only the valid bits.
`default_nettype none

module quadratic_root_solver (
    input  logic i_clk,
    input  logic i_rst_n,
    qrs_in_if.sink    i_in,
    qrs_out_if.source o_out
);

    localparam int LANES = qrs_pkg::LANES;

    logic                           w_en;

    logic                           w_dvld;
    qrs_pkg::t_pre                  w_dpre;
    logic [qrs_pkg::RADP_W-1:0]     w_drad;

    logic                           w_svld;
    logic [qrs_pkg::SQ_W-1:0]       w_root;
    qrs_pkg::t_pre                  w_spre;

    logic                           r_nvld;
    qrs_pkg::t_num                  r_num [LANES];
    qrs_pkg::t_den                  r_den;
    qrs_pkg::t_side                 r_nside;
    qrs_pkg::t_num                  n_num [LANES];
    qrs_pkg::t_den                  n_den;
    qrs_pkg::t_num                  w_base, w_r;

    logic                           w_qvld;
    logic [qrs_pkg::QN_W-1:0]       w_quo [LANES];
    logic                           w_neg [LANES];
    qrs_pkg::t_side                 w_qside;

    logic                           r_out_vld;
    qrs_pkg::t_count                r_count;
    logic [qrs_pkg::ROOT_W-1:0]     r_first, r_second;
    qrs_pkg::t_disc                 r_disc;
    logic [qrs_pkg::ROOT_W-1:0]     n_first, n_second;

    // Round-to-nearest quotient magnitude saturated to the signed root range.
    function automatic logic [qrs_pkg::ROOT_W-1:0] f_sat(
        input logic [qrs_pkg::QN_W-1:0] q,
        input logic                     neg
    );
        logic [qrs_pkg::SAT_W-1:0] w;
        w = qrs_pkg::SAT_W'(q);
        if (neg) begin
            if (w > qrs_pkg::SAT_NEG) begin
                w = qrs_pkg::SAT_NEG;
            end
            w = -w;
        end else if (w > qrs_pkg::SAT_POS) begin
            w = qrs_pkg::SAT_POS;
        end
        return w[qrs_pkg::ROOT_W-1:0];
    endfunction

    // The pipeline moves unless a finished result is held at the output.
    assign w_en       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    qrs_disc u_disc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (i_in.valid),
        .i_coef_a (i_in.coef_a),
        .i_coef_b (i_in.coef_b),
        .i_coef_c (i_in.coef_c),
        .o_vld    (w_dvld),
        .o_pre    (w_dpre),
        .o_rad    (w_drad)
    );

    qrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_dvld),
        .i_rad   (w_drad),
        .i_side  (w_dpre),
        .o_vld   (w_svld),
        .o_root  (w_root),
        .o_side  (w_spre)
    );

    // Numerators and divisor: -b*2^F -/+ sqrt over 2a, or -c*2^F over b.
    always_comb begin
        w_base = -(qrs_pkg::t_num'(w_spre.coef_b) <<< qrs_pkg::FRAC_BITS);
        w_r    = qrs_pkg::t_num'(w_root);
        if (w_spre.coef_a == '0) begin
            n_num[0] = -(qrs_pkg::t_num'(w_spre.coef_c) <<< qrs_pkg::FRAC_BITS);
            n_num[1] = '0;
            n_den    = qrs_pkg::t_den'(w_spre.coef_b);
        end else begin
            n_num[0] = w_base - w_r;
            n_num[1] = w_base + w_r;
            n_den    = qrs_pkg::t_den'(w_spre.coef_a) <<< 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nvld <= 1'b0;
        end else if (w_en) begin
            r_nvld <= w_svld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num         <= n_num;
            r_den         <= n_den;
            r_nside.disc  <= w_spre.disc;
            r_nside.count <= w_spre.count;
        end
    end

    qrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_nvld),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  (r_nside),
        .o_vld   (w_qvld),
        .o_quo   (w_quo),
        .o_neg   (w_neg),
        .o_side  (w_qside)
    );

    // Result stage: saturate and zero the roots that the count does not use.
    always_comb begin
        n_first  = '0;
        n_second = '0;
        if (w_qside.count == qrs_pkg::CNT_ONE || w_qside.count == qrs_pkg::CNT_TWO) begin
            n_first = f_sat(w_quo[0], w_neg[0]);
        end
        if (w_qside.count == qrs_pkg::CNT_TWO) begin
            n_second = f_sat(w_quo[1], w_neg[1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_qvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_count  <= w_qside.count;
            r_first  <= n_first;
            r_second <= n_second;
            r_disc   <= w_qside.disc;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.root_count   = r_count;
    assign o_out.first_root   = r_first;
    assign o_out.second_root  = r_second;
    assign o_out.discriminant = r_disc;

endmodule

`default_nettype wire

[rtl/core/qrs_disc.sv]
// Front end: products, exact discriminant, case selection and radicand.
`default_nettype none

module qrs_disc (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  qrs_pkg::t_coef               i_coef_a,
    input  qrs_pkg::t_coef               i_coef_b,
    input  qrs_pkg::t_coef               i_coef_c,
    output logic                         o_vld,
    output qrs_pkg::t_pre                o_pre,
    output logic [qrs_pkg::RADP_W-1:0]   o_rad
);

    logic                                r_vld1;
    qrs_pkg::t_coef                      r_a, r_b, r_c;
    logic signed [qrs_pkg::PROD_W-1:0]   r_bb, r_ac;

    logic                                r_vld2;
    qrs_pkg::t_pre                       r_pre;
    logic [qrs_pkg::RADP_W-1:0]          r_rad;

    qrs_pkg::t_disc                      n_disc;
    qrs_pkg::t_count                     n_count;
    logic [qrs_pkg::RADP_W-1:0]          n_rad;

    // Stage one: the two products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a  <= i_coef_a;
            r_b  <= i_coef_b;
            r_c  <= i_coef_c;
            r_bb <= i_coef_b * i_coef_b;
            r_ac <= i_coef_a * i_coef_c;
        end
    end

    // Stage two: discriminant and the kind of equation.
    always_comb begin
        n_disc = qrs_pkg::t_disc'(r_bb) - (qrs_pkg::t_disc'(r_ac) <<< 2);
        if (r_a == '0) begin
            if (r_b != '0) begin
                n_count = qrs_pkg::CNT_ONE;
            end else if (r_c == '0) begin
                n_count = qrs_pkg::CNT_ALL;
            end else begin
                n_count = qrs_pkg::CNT_NONE;
            end
        end else if (n_disc > 0) begin
            n_count = qrs_pkg::CNT_TWO;
        end else if (n_disc == '0) begin
            n_count = qrs_pkg::CNT_ONE;
        end else begin
            n_count = qrs_pkg::CNT_NONE;
        end
        // Only two distinct roots need a square root; otherwise it is zero.
        if (n_count == qrs_pkg::CNT_TWO) begin
            n_rad = qrs_pkg::RADP_W'(n_disc[qrs_pkg::RAD_W-2*qrs_pkg::FRAC_BITS-1:0])
                    << (2 * qrs_pkg::FRAC_BITS);
        end else begin
            n_rad = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre.coef_a <= r_a;
            r_pre.coef_b <= r_b;
            r_pre.coef_c <= r_c;
            r_pre.disc   <= n_disc;
            r_pre.count  <= n_count;
            r_rad        <= n_rad;
        end
    end

    assign o_vld = r_vld2;
    assign o_pre = r_pre;
    assign o_rad = r_rad;

endmodule

`default_nettype wire

[rtl/core/qrs_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module qrs_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [qrs_pkg::RADP_W-1:0]   i_rad,
    input  qrs_pkg::t_pre                i_side,
    output logic                         o_vld,
    output logic [qrs_pkg::SQ_W-1:0]     o_root,
    output qrs_pkg::t_pre                o_side
);

    localparam int SQ_W   = qrs_pkg::SQ_W;
    localparam int REM_W  = qrs_pkg::REM_W;
    localparam int RADP_W = qrs_pkg::RADP_W;

    logic [REM_W-1:0]   r_rem  [SQ_W];
    logic [SQ_W-1:0]    r_root [SQ_W];
    logic [RADP_W-1:0]  r_rad  [SQ_W];
    qrs_pkg::t_pre      r_side [SQ_W];
    logic [SQ_W-1:0]    r_vld;

    for (genvar s = 0; s < SQ_W; s++) begin : g_stage
        logic [REM_W-1:0]  p_rem, w_sh, w_trial, n_rem;
        logic [SQ_W-1:0]   p_root, n_root;
        logic [RADP_W-1:0] p_rad;
        qrs_pkg::t_pre     p_side;
        logic              p_vld;

        if (s == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_side = i_side;
            assign p_vld  = i_vld;
        end else begin : g_next
            assign p_rem  = r_rem[s-1];
            assign p_root = r_root[s-1];
            assign p_rad  = r_rad[s-1];
            assign p_side = r_side[s-1];
            assign p_vld  = r_vld[s-1];
        end

        // Bring down the next two radicand bits and try to set a root bit.
        always_comb begin
            w_sh    = {p_rem[REM_W-3:0], p_rad[RADP_W-1 -: 2]};
            w_trial = {p_root, 2'b01};
            if (w_sh >= w_trial) begin
                n_rem  = w_sh - w_trial;
                n_root = {p_root[SQ_W-2:0], 1'b1};
            end else begin
                n_rem  = w_sh;
                n_root = {p_root[SQ_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
                r_rad[s]  <= p_rad << 2;
                r_side[s] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[SQ_W-1];
    assign o_root = r_root[SQ_W-1];
    assign o_side = r_side[SQ_W-1];

endmodule

`default_nettype wire

[rtl/core/qrs_div.sv]
// Pipelined two-lane restoring divider with round-half-up bias, shared divisor.
`default_nettype none

module qrs_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  qrs_pkg::t_num                i_num [qrs_pkg::LANES],
    input  qrs_pkg::t_den                i_den,
    input  qrs_pkg::t_side               i_side,
    output logic                         o_vld,
    output logic [qrs_pkg::QN_W-1:0]     o_quo [qrs_pkg::LANES],
    output logic                         o_neg [qrs_pkg::LANES],
    output qrs_pkg::t_side               o_side
);

    localparam int QN_W  = qrs_pkg::QN_W;
    localparam int DEN_W = qrs_pkg::DEN_W;
    localparam int UN_W  = qrs_pkg::UN_W;
    localparam int LANES = qrs_pkg::LANES;

    // Prepare stage: magnitudes, signs and the rounding bias.
    logic                 r_pvld;
    logic [DEN_W-1:0]     r_pud;
    qrs_pkg::t_side       r_pside;
    logic [QN_W-1:0]      r_pdq  [LANES];
    logic                 r_pneg [LANES];

    logic [DEN_W-1:0]     n_ud;
    logic [UN_W-1:0]      n_un   [LANES];
    logic [QN_W-1:0]      n_dq   [LANES];
    logic                 n_neg  [LANES];

    always_comb begin
        n_ud = i_den[qrs_pkg::DENS_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
        for (int l = 0; l < LANES; l++) begin
            n_un[l]  = i_num[l][qrs_pkg::NS_W-1] ? UN_W'(-i_num[l]) : UN_W'(i_num[l]);
            n_dq[l]  = QN_W'(n_un[l]) + QN_W'(n_ud >> 1);
            n_neg[l] = i_num[l][qrs_pkg::NS_W-1] ^ i_den[qrs_pkg::DENS_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else if (i_en) begin
            r_pvld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pud   <= n_ud;
            r_pside <= i_side;
            r_pdq   <= n_dq;
            r_pneg  <= n_neg;
        end
    end

    // Quotient stages, one quotient bit per stage in each lane.
    logic [QN_W-1:0]      r_dq   [QN_W][LANES];
    logic [DEN_W-1:0]     r_rem  [QN_W][LANES];
    logic                 r_neg  [QN_W][LANES];
    logic [DEN_W-1:0]     r_ud   [QN_W];
    qrs_pkg::t_side       r_side [QN_W];
    logic [QN_W-1:0]      r_vld;

    for (genvar s = 0; s < QN_W; s++) begin : g_stage
        logic [QN_W-1:0]  p_dq   [LANES];
        logic [DEN_W-1:0] p_rem  [LANES];
        logic             p_neg  [LANES];
        logic [DEN_W-1:0] p_ud;
        qrs_pkg::t_side   p_side;
        logic             p_vld;
        logic [DEN_W:0]   w_sh   [LANES];
        logic [QN_W-1:0]  n_sdq  [LANES];
        logic [DEN_W-1:0] n_srem [LANES];

        if (s == 0) begin : g_first
            assign p_dq   = r_pdq;
            assign p_neg  = r_pneg;
            assign p_ud   = r_pud;
            assign p_side = r_pside;
            assign p_vld  = r_pvld;
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign p_rem[l] = '0;
            end
        end else begin : g_next
            assign p_dq   = r_dq[s-1];
            assign p_rem  = r_rem[s-1];
            assign p_neg  = r_neg[s-1];
            assign p_ud   = r_ud[s-1];
            assign p_side = r_side[s-1];
            assign p_vld  = r_vld[s-1];
        end

        // Shift in one dividend bit and subtract the divisor when it fits.
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_sh[l] = {p_rem[l], p_dq[l][QN_W-1]};
                if (w_sh[l] >= {1'b0, p_ud}) begin
                    n_srem[l] = DEN_W'(w_sh[l] - {1'b0, p_ud});
                    n_sdq[l]  = {p_dq[l][QN_W-2:0], 1'b1};
                end else begin
                    n_srem[l] = DEN_W'(w_sh[l]);
                    n_sdq[l]  = {p_dq[l][QN_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dq[s]   <= n_sdq;
                r_rem[s]  <= n_srem;
                r_neg[s]  <= p_neg;
                r_ud[s]   <= p_ud;
                r_side[s] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[QN_W-1];
    assign o_quo  = r_dq[QN_W-1];
    assign o_neg  = r_neg[QN_W-1];
    assign o_side = r_side[QN_W-1];

endmodule

`default_nettype wire

[rtl/core/qrs_checker.sv]
// Port-level checks of the quadratic root solver, bound to the top level.
`default_nettype none

module qrs_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_ready,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [qrs_pkg::CNT_W-1:0]          i_count,
    input  logic [qrs_pkg::ROOT_W-1:0]         i_first,
    input  logic [qrs_pkg::ROOT_W-1:0]         i_second,
    input  logic [qrs_pkg::DISC_W-1:0]         i_disc
);

    // A held result keeps its payload until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_count)
            && $stable(i_first) && $stable(i_second) && $stable(i_disc))
        else $error("result item changed while stalled");

    // Input is taken exactly when the output side is free to move.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    // No result leaves the block in the cycle after reset.
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // Two roots only come with a strictly positive discriminant.
    a_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_count == qrs_pkg::CNT_TWO |->
            !i_disc[qrs_pkg::DISC_W-1] && i_disc != '0)
        else $error("two roots with non-positive discriminant");

    // With no root, or with every value a root, both root fields are zero.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_count == qrs_pkg::CNT_NONE || i_count == qrs_pkg::CNT_ALL) |->
            i_first == '0 && i_second == '0)
        else $error("nonzero root reported without a root");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_count     (o_out.root_count),
    .i_first     (o_out.first_root),
    .i_second    (o_out.second_root),
    .i_disc      (o_out.discriminant)
);

`default_nettype wire
